// ----- sv/wmr_pkg.sv -----
// Package for the waveform min/max rescaler.
// Holds widths, sample limits, register indexes and shared types.
// No dependencies.
`default_nettype none

package wmr_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_BITS      = 3;
    localparam int CNT_BITS     = 4;
    localparam int SAMPLE_BITS  = 16;
    localparam int POS_BITS     = 48;
    localparam int IN_SPP_BITS  = 21;
    localparam int OUT_SPP_BITS = 25;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = OUT_SPP_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_HI = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_LO = 16'sh8000;

    localparam logic [IN_SPP_BITS-1:0]  IN_SPP_RESET  = 21'd256;
    localparam logic [OUT_SPP_BITS-1:0] OUT_SPP_RESET = 25'd512;
    localparam logic [CNT_BITS-1:0]     CH_CNT_RESET  = 4'd1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IN_SPP   = 2'd0,
        CFG_OUT_SPP  = 2'd1,
        CFG_CH_COUNT = 2'd2
    } t_cfg_idx;

    // One running min/max pair as held in the channel memory.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] max;
        logic signed [SAMPLE_BITS-1:0] min;
    } t_mm;

    typedef struct packed {
        logic               en;
        logic [CH_BITS-1:0] addr;
        t_mm                data;
    } t_ram_wr;

    typedef struct packed {
        logic               en;
        logic [CH_BITS-1:0] addr;
    } t_ram_rd;

endpackage

`default_nettype wire

// ----- sv/wmr_pt_if.sv -----
// Input channel of the rescaler: one waveform point per transfer.
// Depends on wmr_pkg for the sample width.
`default_nettype none

interface wmr_pt_if;
    import wmr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_min;
    logic signed [SAMPLE_BITS-1:0] in_max;
    logic                          final_pixel;

    modport source (output valid, output in_min, output in_max, output final_pixel,
                    input ready);
    modport sink   (input valid, input in_min, input in_max, input final_pixel,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/wmr_res_if.sv -----
// Output channel of the rescaler: one merged min/max pair per transfer.
// Depends on wmr_pkg for the sample and channel widths.
`default_nettype none

interface wmr_res_if;
    import wmr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_min;
    logic signed [SAMPLE_BITS-1:0] out_max;
    logic [CH_BITS-1:0]            out_channel;

    modport source (output valid, output out_min, output out_max, output out_channel,
                    input ready);
    modport sink   (input valid, input out_min, input out_max, input out_channel,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/waveform_minmax_rescaler.sv -----
// Top level of the waveform min/max rescaler.
// Depends on wmr_pkg, wmr_pt_if, wmr_res_if and wmr_mm_ram.
`default_nettype none

// The block accepts one waveform point per clock cycle while input flow is not
// stopped and delivers a merged pair for each point that closes a span or
// belongs to a final pixel: the span decision and the pixel accumulators are
// updated at the input transfer, the channel's running pair is read from an
// 8-entry memory with a registered read, merged, and written back or, for an
// emitting point, held in an output register. Back-to-back points of the same
// channel are bypassed at the memory read port. A per-channel valid bit stands
// for the reset extremes, so a restart (reset, a configuration write, or the
// last channel of a final pixel) takes effect at once with no clearing pass.
// Input flow stops only while an emitting point waits on an untaken output.
module waveform_minmax_rescaler (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [wmr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [wmr_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    wmr_pt_if.sink                               i_pt,
    wmr_res_if.source                            o_res
);
    import wmr_pkg::*;

    // Configuration and stream position.
    logic [IN_SPP_BITS-1:0]  r_in_spp, n_in_spp;
    logic [OUT_SPP_BITS-1:0] r_out_spp, n_out_spp;
    logic [CNT_BITS-1:0]     r_ch_cnt, n_ch_cnt;
    logic [CH_BITS-1:0]      r_pos, n_pos;
    logic [POS_BITS-1:0]     r_pe, n_pe;
    logic [POS_BITS-1:0]     r_sb, n_sb;

    // Merge stage.
    logic                          r_s1_v;
    logic [CH_BITS-1:0]            r_s1_ch;
    logic                          r_s1_emit;
    logic                          r_s1_restart;
    logic signed [SAMPLE_BITS-1:0] r_s1_min;
    logic signed [SAMPLE_BITS-1:0] r_s1_max;

    logic [MAX_CHANNELS-1:0] r_vld;

    // Output register.
    logic                          r_out_v;
    logic signed [SAMPLE_BITS-1:0] r_out_min;
    logic signed [SAMPLE_BITS-1:0] r_out_max;
    logic [CH_BITS-1:0]            r_out_ch;

    logic                cfg_hit;
    logic                accept;
    logic                out_free;
    logic                s1_go;
    logic [CNT_BITS-1:0] nch;
    logic [CH_BITS-1:0]  ch_in;
    logic [POS_BITS-1:0] diff;
    logic                closes;
    logic                emit_in;
    logic                last_in;
    t_mm                 rd_data;
    t_mm                 old_mm;
    t_mm                 new_mm;
    t_ram_wr             ram_wr;
    t_ram_rd             ram_rd;

    // Input side: span decision and channel position.
    always_comb begin
        if (r_ch_cnt == '0) begin
            nch = CNT_BITS'(1);
        end else if (r_ch_cnt > CNT_BITS'(MAX_CHANNELS)) begin
            nch = CNT_BITS'(MAX_CHANNELS);
        end else begin
            nch = r_ch_cnt;
        end
        ch_in   = ({1'b0, r_pos} >= nch) ? '0 : r_pos;
        diff    = r_pe - r_sb;
        closes  = (diff != '0) && !diff[POS_BITS-1];
        emit_in = closes || i_pt.final_pixel;
        last_in = (({1'b0, ch_in} + CNT_BITS'(1)) >= nch);
    end

    assign out_free   = !r_out_v || o_res.ready;
    assign s1_go      = r_s1_v && (!r_s1_emit || out_free);
    assign i_pt.ready = !r_s1_v || s1_go;
    assign accept     = i_pt.valid && i_pt.ready;

    always_comb begin
        cfg_hit = 1'b0;
        n_in_spp  = r_in_spp;
        n_out_spp = r_out_spp;
        n_ch_cnt  = r_ch_cnt;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IN_SPP: begin
                    cfg_hit  = 1'b1;
                    n_in_spp = i_cfg_data[IN_SPP_BITS-1:0];
                end
                CFG_OUT_SPP: begin
                    cfg_hit   = 1'b1;
                    n_out_spp = i_cfg_data[OUT_SPP_BITS-1:0];
                end
                CFG_CH_COUNT: begin
                    cfg_hit  = 1'b1;
                    n_ch_cnt = i_cfg_data[CNT_BITS-1:0];
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        n_pos = r_pos;
        n_pe  = r_pe;
        n_sb  = r_sb;
        if (cfg_hit || (accept && last_in && i_pt.final_pixel)) begin
            n_pos = '0;
            n_pe  = {{(POS_BITS-IN_SPP_BITS-1){1'b0}}, n_in_spp, 1'b0};
            n_sb  = {{(POS_BITS-OUT_SPP_BITS){1'b0}}, n_out_spp};
        end else if (accept) begin
            if (last_in) begin
                n_pos = '0;
                n_pe  = r_pe + {{(POS_BITS-IN_SPP_BITS){1'b0}}, r_in_spp};
                if (closes) begin
                    n_sb = r_sb + {{(POS_BITS-OUT_SPP_BITS){1'b0}}, r_out_spp};
                end
            end else begin
                n_pos = ch_in + CH_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_spp  <= IN_SPP_RESET;
            r_out_spp <= OUT_SPP_RESET;
            r_ch_cnt  <= CH_CNT_RESET;
            r_pos     <= '0;
            r_pe      <= {{(POS_BITS-IN_SPP_BITS-1){1'b0}}, IN_SPP_RESET, 1'b0};
            r_sb      <= {{(POS_BITS-OUT_SPP_BITS){1'b0}}, OUT_SPP_RESET};
        end else begin
            r_in_spp  <= n_in_spp;
            r_out_spp <= n_out_spp;
            r_ch_cnt  <= n_ch_cnt;
            r_pos     <= n_pos;
            r_pe      <= n_pe;
            r_sb      <= n_sb;
        end
    end

    // Merge stage: the memory read issued at the input transfer lands here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (s1_go) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ch      <= ch_in;
            r_s1_emit    <= emit_in;
            r_s1_restart <= last_in && i_pt.final_pixel;
            r_s1_min     <= i_pt.in_min;
            r_s1_max     <= i_pt.in_max;
        end
    end

    always_comb begin
        if (r_vld[r_s1_ch]) begin
            old_mm = rd_data;
        end else begin
            old_mm.min = SAMPLE_HI;
            old_mm.max = SAMPLE_LO;
        end
        new_mm.min = (r_s1_min < old_mm.min) ? r_s1_min : old_mm.min;
        new_mm.max = (r_s1_max > old_mm.max) ? r_s1_max : old_mm.max;

        ram_wr.en   = s1_go && !r_s1_emit;
        ram_wr.addr = r_s1_ch;
        ram_wr.data = new_mm;
        ram_rd.en   = accept;
        ram_rd.addr = ch_in;
    end

    // An emitted entry goes back to the extremes by dropping its valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_vld <= '0;
        end else if (s1_go) begin
            if (r_s1_restart) begin
                r_vld <= '0;
            end else begin
                r_vld[r_s1_ch] <= !r_s1_emit;
            end
        end
    end

    wmr_mm_ram u_mm_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd      (ram_rd),
        .o_rd_data (rd_data)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_go && r_s1_emit) begin
            r_out_v <= 1'b1;
        end else if (o_res.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_emit) begin
            r_out_min <= new_mm.min;
            r_out_max <= new_mm.max;
            r_out_ch  <= r_s1_ch;
        end
    end

    assign o_res.valid       = r_out_v;
    assign o_res.out_min     = r_out_min;
    assign o_res.out_max     = r_out_max;
    assign o_res.out_channel = r_out_ch;

endmodule

`default_nettype wire

// ----- sv/wmr_mm_ram.sv -----
// Per-channel running min/max memory: one write and one registered read port.
// A read at the edge of a write to the same entry returns the new data.
// Depends on wmr_pkg.
`default_nettype none

module wmr_mm_ram (
    input  wire logic             i_clk,
    input  wire wmr_pkg::t_ram_wr i_wr,
    input  wire wmr_pkg::t_ram_rd i_rd,
    output wmr_pkg::t_mm          o_rd_data
);
    import wmr_pkg::*;

    t_mm r_mem [MAX_CHANNELS];
    t_mm r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            if (i_wr.en && (i_wr.addr == i_rd.addr)) begin
                r_rd_data <= i_wr.data;
            end else begin
                r_rd_data <= r_mem[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
